>>> rtl/estc_pkg.sv
// ----------------------------------------------------------------------------
// Environmental sensor trim compensation package
// Shared types, register codes and arithmetic helpers of the compensation
// pipeline.
// ----------------------------------------------------------------------------
package estc_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 64;

  localparam logic [CfgIdxW-1:0] CFG_TEMP_TRIM = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_PRESS_TRIM_A = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_PRESS_TRIM_B = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_PRESS_TRIM_C = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_HUM_TRIM = 3'd4;

  localparam int DivBits = 32;
  localparam int DivFirst = 13;
  localparam int DivLast = DivFirst + DivBits - 1;
  localparam int NumStages = DivLast + 4;

  localparam logic [31:0] HumMax = 32'd419430400;

  typedef struct packed {
    logic [31:0] t1, t2, t3;
    logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] h1, h2, h3, h4, h5, h6;
  } trim_t;

  typedef struct packed {
    logic [19:0] raw_t;
    logic [19:0] raw_p;
    logic [15:0] raw_h;
    logic [31:0] w0, w1, w2, w3, w4, w5, w6;
    logic [31:0] fine;
    logic [31:0] temp;
    logic [16:0] hum;
    logic        inv;
    logic        big;
    logic [31:0] rem;
    logic [31:0] quo;
  } stage_t;

  function automatic logic [31:0] asr(input logic [31:0] x, input int n);
    return 32'($signed(x) >>> n);
  endfunction

  function automatic logic [31:0] mul(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] r;
    r = 64'(a) * 64'(b);
    return r[31:0];
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] x);
    return {{16{x[15]}}, x};
  endfunction

  function automatic logic [31:0] sx12(input logic [11:0] x);
    return {{20{x[11]}}, x};
  endfunction

  function automatic logic [31:0] sx8(input logic [7:0] x);
    return {{24{x[7]}}, x};
  endfunction

  // One pipeline stage; stage k reads its register and gives the next one.
  function automatic stage_t stage_step(input int k, input stage_t c, input trim_t tr);
    stage_t n;
    logic [31:0] x, d, pa, q, v, p;
    logic [32:0] r;
    n = c;
    x = 32'd0;
    d = 32'd0;
    pa = 32'd0;
    q = 32'd0;
    v = 32'd0;
    p = 32'd0;
    r = 33'd0;
    if (k == 0) begin
      x = (32'(c.raw_t) >> 3) - (tr.t1 << 1);
      d = (32'(c.raw_t) >> 4) - tr.t1;
      n.w0 = mul(x, tr.t2);
      n.w1 = mul(d, d);
    end else if (k == 1) begin
      n.w0 = asr(c.w0, 11);
      n.w1 = mul(asr(c.w1, 12), tr.t3);
    end else if (k == 2) begin
      n.fine = c.w0 + asr(c.w1, 14);
    end else if (k == 3) begin
      pa = asr(c.fine, 1) - 32'd64000;
      q = asr(pa, 2);
      v = c.fine - 32'd76800;
      n.temp = mul(c.fine, 32'd5);
      n.w0 = mul(q, q);
      n.w1 = mul(pa, tr.p5);
      n.w2 = mul(tr.p2, pa);
      n.w3 = mul(tr.h5, v);
      n.w4 = mul(v, tr.h3);
      n.w5 = mul(v, tr.h6);
    end else if (k == 4) begin
      n.temp = asr(c.temp + 32'd128, 8);
      n.w0 = mul(asr(c.w0, 11), tr.p6);
      n.w6 = mul(tr.p3, asr(c.w0, 13));
      n.w1 = c.w1 << 1;
      n.w2 = asr(c.w2, 1);
      n.w3 = asr((32'(c.raw_h) << 14) - (tr.h4 << 20) - c.w3 + 32'd16384, 15);
      n.w4 = asr(c.w4, 11) + 32'd32768;
      n.w5 = asr(c.w5, 10);
    end else if (k == 5) begin
      n.w0 = asr(c.w0 + c.w1, 2) + (tr.p4 << 16);
      n.w2 = asr(asr(c.w6, 3) + c.w2, 18);
      n.w5 = mul(c.w5, c.w4);
    end else if (k == 6) begin
      n.w2 = mul(32'd32768 + c.w2, tr.p1);
      n.w0 = asr(c.w0, 12);
      n.w5 = asr(c.w5, 10) + 32'd2097152;
    end else if (k == 7) begin
      n.w2 = asr(c.w2, 15);
      n.w0 = mul((32'd1048576 - 32'(c.raw_p)) - c.w0, 32'd3125);
      n.w5 = mul(c.w5, tr.h2);
    end else if (k == 8) begin
      n.w5 = asr(c.w5 + 32'd8192, 14);
      n.inv = (c.w2 == 32'd0);
      n.big = c.w0[31];
      n.quo = c.w0[31] ? c.w0 : (c.w0 << 1);
      n.rem = 32'd0;
    end else if (k == 9) begin
      n.w5 = mul(c.w3, c.w5);
    end else if (k == 10) begin
      q = asr(c.w5, 15);
      n.w3 = mul(q, q);
    end else if (k == 11) begin
      n.w3 = mul(asr(c.w3, 7), tr.h1);
    end else if (k == 12) begin
      v = c.w5 - asr(c.w3, 4);
      if (v[31]) begin
        v = 32'd0;
      end
      if (v > HumMax) begin
        v = HumMax;
      end
      n.hum = v[28:12];
    end else if (k <= DivLast) begin
      r = {c.rem, c.quo[31]};
      if (r >= {1'b0, c.w2}) begin
        r = r - {1'b0, c.w2};
        n.quo = {c.quo[30:0], 1'b1};
      end else begin
        n.quo = {c.quo[30:0], 1'b0};
      end
      n.rem = r[31:0];
    end else if (k == DivLast + 1) begin
      p = c.big ? (c.quo << 1) : c.quo;
      n.w2 = p;
      n.w0 = mul(p >> 3, p >> 3);
      n.w1 = mul(p >> 2, tr.p8);
    end else if (k == DivLast + 2) begin
      n.w0 = asr(mul(tr.p9, c.w0 >> 13), 12);
      n.w1 = asr(c.w1, 13);
    end else begin
      p = c.w2 + asr(c.w0 + c.w1 + tr.p7, 4);
      n.w2 = c.inv ? 32'd0 : p;
    end
    return n;
  endfunction

endpackage

>>> rtl/env_sensor_trim_compensation_top.sv
// ----------------------------------------------------------------------------
// Environmental sensor trim compensation
// Pipelined 32-bit integer trim compensation of temperature, pressure and
// humidity, with a bit-per-stage pressure divider.
// ----------------------------------------------------------------------------
//  Channel | Signals                                   | Direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_stall, raw_*                 | sink
//  out     | out_valid, out_stall, result fields       | source
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | sink
//
// One transaction enters per cycle while the output is not stalled; each result leaves after every stage.
// Most of the stages form the 32-stage restoring divider of the pressure path.
// A stall on a valid output freezes the whole pipeline and is passed to in_stall.
// Reset clears every valid bit and all trim registers.
// Configuration writes are always ready.
// ----------------------------------------------------------------------------
module env_sensor_trim_compensation_top (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [19:0]                           raw_temperature,
  input  logic [19:0]                           raw_pressure,
  input  logic [15:0]                           raw_humidity,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [31:0]                    temperature_centi,
  output logic [31:0]                           pressure_pa,
  output logic [16:0]                           humidity_q10,
  output logic                                  pressure_invalid,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [estc_pkg::CfgIdxW-1:0]          cfg_index,
  input  logic [estc_pkg::CfgDataW-1:0]         cfg_data
);
  import estc_pkg::*;

  logic [47:0] temp_trim;
  logic [63:0] press_trim_a;
  logic [63:0] press_trim_b;
  logic [15:0] press_trim_c;
  logic [63:0] hum_trim;
  trim_t       tr;
  stage_t      st_in;
  stage_t      st [0:NumStages];
  stage_t      st_next [0:NumStages-1];
  logic        vld [0:NumStages];
  logic        adv;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_trim <= '0;
      press_trim_a <= '0;
      press_trim_b <= '0;
      press_trim_c <= '0;
      hum_trim <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TEMP_TRIM:    temp_trim <= cfg_data[47:0];
        CFG_PRESS_TRIM_A: press_trim_a <= cfg_data;
        CFG_PRESS_TRIM_B: press_trim_b <= cfg_data;
        CFG_PRESS_TRIM_C: press_trim_c <= cfg_data[15:0];
        CFG_HUM_TRIM:     hum_trim <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    tr.t1 = {16'd0, temp_trim[15:0]};
    tr.t2 = sx16(temp_trim[31:16]);
    tr.t3 = sx16(temp_trim[47:32]);
    tr.p1 = {16'd0, press_trim_a[15:0]};
    tr.p2 = sx16(press_trim_a[31:16]);
    tr.p3 = sx16(press_trim_a[47:32]);
    tr.p4 = sx16(press_trim_a[63:48]);
    tr.p5 = sx16(press_trim_b[15:0]);
    tr.p6 = sx16(press_trim_b[31:16]);
    tr.p7 = sx16(press_trim_b[47:32]);
    tr.p8 = sx16(press_trim_b[63:48]);
    tr.p9 = sx16(press_trim_c);
    tr.h1 = {24'd0, hum_trim[7:0]};
    tr.h2 = sx16(hum_trim[23:8]);
    tr.h3 = {24'd0, hum_trim[31:24]};
    tr.h4 = sx12(hum_trim[43:32]);
    tr.h5 = sx12(hum_trim[55:44]);
    tr.h6 = sx8(hum_trim[63:56]);
  end

  assign adv = !(vld[NumStages] && out_stall);
  assign in_stall = !adv;

  always_comb begin
    st_in = '0;
    st_in.raw_t = raw_temperature;
    st_in.raw_p = raw_pressure;
    st_in.raw_h = raw_humidity;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st[0] <= st_in;
    end
  end

  for (genvar k = 0; k < NumStages; k++) begin : g_stage
    assign st_next[k] = stage_step(k, st[k], tr);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (adv) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st[k+1] <= st_next[k];
      end
    end
  end

  assign out_valid = vld[NumStages];
  assign temperature_centi = $signed(st[NumStages].temp);
  assign pressure_pa = st[NumStages].w2;
  assign humidity_q10 = st[NumStages].hum;
  assign pressure_invalid = st[NumStages].inv;

  a_inv_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && pressure_invalid |-> pressure_pa == 32'd0)
    else $error("Pressure not forced to zero on a zero divisor.");

  a_hum_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> humidity_q10 <= 17'd102400)
    else $error("Humidity above the clamp limit.");

  a_stall_path: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("Input stall does not follow the output register.");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("Result presented straight after reset.");

endmodule
